@@ rtl/core/line_pixel_rasterizer_unit_defines.svh @@
// Assertion macros shared by the line rasterizer RTL.
// Expects clk and arst_n to exist in the scope where a macro is used.
`ifndef LINE_PIXEL_RASTERIZER_UNIT_DEFINES_SVH
`define LINE_PIXEL_RASTERIZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("line rasterizer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("line rasterizer check failed");

`endif

@@ rtl/core/lpr_pkg.sv @@
// Package for the line rasterizer: widths, register and command codes, shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpr_pkg;

	localparam int CoordBits = 12;
	localparam int ErrBits   = CoordBits + 1;
	localparam int CountBits = CoordBits + 1;
	localparam int DimBits   = 12;
	localparam int PitchBits = 15;
	localparam int PixBytesBits = 3;
	localparam int AddrBits  = 32;
	localparam int ColorBits = 32;
	localparam int CfgDataBits  = 32;
	localparam int CfgIndexBits = 3;
	localparam int CmpBits   = (CoordBits > DimBits) ? CoordBits : DimBits;
	localparam int ProdYBits = CoordBits + PitchBits + 1;
	localparam int ProdXBits = CoordBits + PixBytesBits + 1;

	typedef logic signed [CoordBits-1:0] lpr_coord_t;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} lpr_cmd_t;

	typedef enum logic [CfgIndexBits-1:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_ROW_PITCH     = 3'd2,
		REG_PIXEL_BYTES   = 3'd3,
		REG_FRAME_BASE    = 3'd4
	} lpr_reg_idx_t;

	typedef struct packed {
		logic [DimBits-1:0]      screen_width;
		logic [DimBits-1:0]      screen_height;
		logic [PitchBits-1:0]    row_pitch_bytes;
		logic [PixBytesBits-1:0] pixel_bytes;
		logic [AddrBits-1:0]     frame_base;
	} lpr_cfg_t;

	// One result word on its way to the address stages.
	typedef struct packed {
		lpr_coord_t           x;
		lpr_coord_t           y;
		logic [ColorBits-1:0] color;
		logic                 visible;
		logic                 last;
		logic                 active;
		logic                 is_pixel;
	} lpr_pix_t;

endpackage

`default_nettype wire

@@ rtl/core/lpr_if.sv @@
// Valid/ready channel interfaces of the line rasterizer: command words in, pixel words out.
// Depends on lpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lpr_cmd_if;
	import lpr_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 command;
	lpr_coord_t           start_x;
	lpr_coord_t           start_y;
	lpr_coord_t           end_x;
	lpr_coord_t           end_y;
	logic [ColorBits-1:0] line_color;

	modport source (
		output valid, command, start_x, start_y, end_x, end_y, line_color,
		input  ready
	);
	modport sink (
		input  valid, command, start_x, start_y, end_x, end_y, line_color,
		output ready
	);
endinterface

interface lpr_pix_if;
	import lpr_pkg::*;

	logic                 valid;
	logic                 ready;
	lpr_coord_t           out_x;
	lpr_coord_t           out_y;
	logic [AddrBits-1:0]  write_address;
	logic [ColorBits-1:0] write_color;
	logic                 write_enable;
	logic                 last_pixel;
	logic                 line_active;

	modport source (
		output valid, out_x, out_y, write_address, write_color, write_enable,
		       last_pixel, line_active,
		input  ready
	);
	modport sink (
		input  valid, out_x, out_y, write_address, write_color, write_enable,
		       last_pixel, line_active,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/core/line_pixel_rasterizer_unit.sv @@
// Line rasterizer top level: configuration registers, Bresenham stepper and address stages.
// Depends on lpr_pkg, lpr_if, lpr_cfg_regs, lpr_stepper and lpr_addr_pipe.
//
// Usage:
// Commands arrive as words on the cmd channel and results leave as words on the pix
// channel; both use valid/ready and a word moves when both are high at a rising edge.
// A start command latches both endpoints and the colour and answers with one word that
// has only line_active set. Each step command answers with one pixel: coordinates,
// byte address (frame_base + y*row_pitch_bytes + x*pixel_bytes, modulo 2^32), colour,
// write_enable when the pixel is on screen, and last_pixel on the final one. A step
// while no line is active answers with an all-zero word. A start always replaces any
// line in progress.
// Every command gives exactly one result word, carried through the stepper register,
// product register and output register in turn; while the receiver keeps ready high a
// command may be accepted in every cycle and the block sustains one pixel per clock.
// Both products, y by row pitch and x by pixel size, are held in the product register.
// When the receiver holds ready low, the output word stays put and the stages behind
// it fill up; cmd.ready drops once all three are full and rises as soon as one moves.
// The configuration port writes one register per cycle with cfg_wr_en; it is meant to
// be written only while no word is in flight. Reset (arst_n low) empties the pipeline,
// ends any line and returns the registers to 640 x 480, pitch 2560, 4 bytes, base 0.
`timescale 1ns / 1ps
`default_nettype none

module line_pixel_rasterizer_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [lpr_pkg::CfgIndexBits-1:0] cfg_index,
	input  wire logic [lpr_pkg::CfgDataBits-1:0]  cfg_wdata,
	lpr_cmd_if.sink                               cmd,
	lpr_pix_if.source                             pix
);
	import lpr_pkg::*;

	// Register file contents, shared by the on-screen test and the address stages.
	lpr_cfg_t cfg;

	// First pipeline stage: one result word per accepted command.
	logic     pix_v_s1;
	lpr_pix_t pix_s1;
	logic     s1_take;

	lpr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The stepper holds the line state and advances it by one pixel per step word.
	lpr_stepper u_stepper (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg),
		.s1_take  (s1_take),
		.pix_v_s1 (pix_v_s1),
		.pix_s1   (pix_s1)
	);

	// The address stages form the byte address and drive the output register.
	lpr_addr_pipe u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.pix_v_s1 (pix_v_s1),
		.pix_s1   (pix_s1),
		.s1_take  (s1_take),
		.pix      (pix)
	);

endmodule

`default_nettype wire

@@ rtl/core/lpr_cfg_regs.sv @@
// Configuration register file of the line rasterizer (screen size, pitch, pixel size, base).
// Depends on lpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpr_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [lpr_pkg::CfgIndexBits-1:0]   cfg_index,
	input  wire logic [lpr_pkg::CfgDataBits-1:0]    cfg_wdata,
	output lpr_pkg::lpr_cfg_t                       cfg
);
	import lpr_pkg::*;

	lpr_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width    <= DimBits'(640);
			cfg_q.screen_height   <= DimBits'(480);
			cfg_q.row_pitch_bytes <= PitchBits'(2560);
			cfg_q.pixel_bytes     <= PixBytesBits'(4);
			cfg_q.frame_base      <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  cfg_q.screen_width    <= cfg_wdata[DimBits-1:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height   <= cfg_wdata[DimBits-1:0];
				REG_ROW_PITCH:     cfg_q.row_pitch_bytes <= cfg_wdata[PitchBits-1:0];
				REG_PIXEL_BYTES:   cfg_q.pixel_bytes     <= cfg_wdata[PixBytesBits-1:0];
				REG_FRAME_BASE:    cfg_q.frame_base      <= cfg_wdata[AddrBits-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/lpr_stepper.sv @@
// Line state and Bresenham step logic; registers one result word per accepted command.
// Depends on lpr_pkg, lpr_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "line_pixel_rasterizer_unit_defines.svh"

module lpr_stepper (
	input  wire logic        clk,
	input  wire logic        arst_n,
	lpr_cmd_if.sink          cmd,
	input  wire lpr_pkg::lpr_cfg_t cfg,
	input  wire logic        s1_take,
	output logic             pix_v_s1,
	output lpr_pkg::lpr_pix_t pix_s1
);
	import lpr_pkg::*;

	lpr_coord_t           cur_x_q, cur_y_q;
	logic [ErrBits-1:0]   err_q;
	logic [CoordBits-1:0] major_q, minor_q;
	logic [CountBits-1:0] left_q;
	logic                 x_major_q, x_neg_q, y_neg_q, busy_q;
	logic [ColorBits-1:0] color_q;

	logic     v_s1_q;
	lpr_pix_t pix_s1_q;

	logic accept, is_start;

	// Start command set-up.
	logic signed [CoordBits:0] dx_raw, dy_raw;
	logic [CoordBits-1:0]      dx, dy;
	logic                      st_x_major;

	// One step from the current state.
	logic [ErrBits-1:0]   acc_sum;
	logic                 minor_adv;
	lpr_coord_t           step_x, step_y, nxt_x, nxt_y;
	logic [CountBits-1:0] nxt_left;
	logic                 nxt_busy;
	logic                 on_screen;
	lpr_pix_t             res;

	assign cmd.ready = !v_s1_q || s1_take;
	assign accept    = cmd.valid && cmd.ready;
	assign is_start  = (cmd.command == CMD_START);

	always_comb begin
		dx_raw = {cmd.end_x[CoordBits-1], cmd.end_x} - {cmd.start_x[CoordBits-1], cmd.start_x};
		dy_raw = {cmd.end_y[CoordBits-1], cmd.end_y} - {cmd.start_y[CoordBits-1], cmd.start_y};
		dx = dx_raw[CoordBits] ? CoordBits'(-dx_raw) : dx_raw[CoordBits-1:0];
		dy = dy_raw[CoordBits] ? CoordBits'(-dy_raw) : dy_raw[CoordBits-1:0];
		st_x_major = (dx >= dy);
	end

	always_comb begin
		acc_sum   = err_q + ErrBits'(minor_q);
		minor_adv = (acc_sum >= ErrBits'(major_q));
		step_x    = x_neg_q ? (cur_x_q - CoordBits'(1)) : (cur_x_q + CoordBits'(1));
		step_y    = y_neg_q ? (cur_y_q - CoordBits'(1)) : (cur_y_q + CoordBits'(1));
		nxt_x     = (x_major_q || minor_adv) ? step_x : cur_x_q;
		nxt_y     = (!x_major_q || minor_adv) ? step_y : cur_y_q;
		nxt_left  = left_q - CountBits'(1);
		nxt_busy  = (nxt_left != '0);
		on_screen = !cur_x_q[CoordBits-1] && !cur_y_q[CoordBits-1] &&
			(CmpBits'($unsigned(cur_x_q)) < CmpBits'(cfg.screen_width)) &&
			(CmpBits'($unsigned(cur_y_q)) < CmpBits'(cfg.screen_height));
	end

	// A start answers with line_active alone; a step while idle answers with all zeros.
	always_comb begin
		res = '0;
		if (is_start) begin
			res.active = 1'b1;
		end else if (busy_q) begin
			res.x        = cur_x_q;
			res.y        = cur_y_q;
			res.color    = color_q;
			res.visible  = on_screen;
			res.last     = !nxt_busy;
			res.active   = nxt_busy;
			res.is_pixel = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			err_q     <= '0;
			major_q   <= '0;
			minor_q   <= '0;
			left_q    <= '0;
			x_major_q <= 1'b0;
			x_neg_q   <= 1'b0;
			y_neg_q   <= 1'b0;
			color_q   <= '0;
			busy_q    <= 1'b0;
		end else if (accept) begin
			if (is_start) begin
				cur_x_q   <= cmd.start_x;
				cur_y_q   <= cmd.start_y;
				x_neg_q   <= dx_raw[CoordBits];
				y_neg_q   <= dy_raw[CoordBits];
				x_major_q <= st_x_major;
				major_q   <= st_x_major ? dx : dy;
				minor_q   <= st_x_major ? dy : dx;
				err_q     <= ErrBits'((st_x_major ? dx : dy) >> 1);
				left_q    <= CountBits'(st_x_major ? dx : dy) + CountBits'(1);
				color_q   <= cmd.line_color;
				busy_q    <= 1'b1;
			end else if (busy_q) begin
				cur_x_q <= nxt_x;
				cur_y_q <= nxt_y;
				err_q   <= minor_adv ? (acc_sum - ErrBits'(major_q)) : acc_sum;
				left_q  <= nxt_left;
				busy_q  <= nxt_busy;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (cmd.ready) begin
			v_s1_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1_q <= res;
		end
	end

	assign pix_v_s1 = v_s1_q;
	assign pix_s1   = pix_s1_q;

	`LPR_ASSERT_NEXT(a_start_sets_busy, accept && is_start, busy_q)
	`LPR_ASSERT_NOW(a_busy_matches_count, 1'b1, busy_q == (left_q != '0))
	`LPR_ASSERT_NOW(a_err_below_major, busy_q, (err_q < ErrBits'(major_q)) || (major_q == '0))

endmodule

`default_nettype wire

@@ rtl/core/lpr_addr_pipe.sv @@
// Address stages: registered products of the coordinates, then the base add and output register.
// Depends on lpr_pkg, lpr_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "line_pixel_rasterizer_unit_defines.svh"

module lpr_addr_pipe (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire lpr_pkg::lpr_cfg_t cfg,
	input  wire logic         pix_v_s1,
	input  wire lpr_pkg::lpr_pix_t pix_s1,
	output logic              s1_take,
	lpr_pix_if.source         pix
);
	import lpr_pkg::*;

	logic                        v_s2_q;
	lpr_pix_t                    pix_s2_q;
	logic signed [ProdYBits-1:0] prod_y_s2;
	logic signed [ProdXBits-1:0] prod_x_s2;
	logic                        s2_take;

	logic                 out_v_q;
	lpr_coord_t           out_x_q, out_y_q;
	logic [AddrBits-1:0]  addr_q;
	logic [ColorBits-1:0] color_q;
	logic                 wen_q, last_q, active_q;
	logic [AddrBits-1:0]  addr_sum;

	assign s2_take = !out_v_q || pix.ready;
	assign s1_take = !v_s2_q || s2_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2_q <= 1'b0;
		end else if (s1_take) begin
			v_s2_q <= pix_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && pix_v_s1) begin
			pix_s2_q  <= pix_s1;
			prod_y_s2 <= pix_s1.y * $signed({1'b0, cfg.row_pitch_bytes});
			prod_x_s2 <= pix_s1.x * $signed({1'b0, cfg.pixel_bytes});
		end
	end

	assign addr_sum = cfg.frame_base + AddrBits'(prod_y_s2) + AddrBits'(prod_x_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s2_take) begin
			out_v_q <= v_s2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_take && v_s2_q) begin
			out_x_q  <= pix_s2_q.x;
			out_y_q  <= pix_s2_q.y;
			addr_q   <= pix_s2_q.is_pixel ? addr_sum : '0;
			color_q  <= pix_s2_q.color;
			wen_q    <= pix_s2_q.visible;
			last_q   <= pix_s2_q.last;
			active_q <= pix_s2_q.active;
		end
	end

	assign pix.valid         = out_v_q;
	assign pix.out_x         = out_x_q;
	assign pix.out_y         = out_y_q;
	assign pix.write_address = addr_q;
	assign pix.write_color   = color_q;
	assign pix.write_enable  = wen_q;
	assign pix.last_pixel    = last_q;
	assign pix.line_active   = active_q;

	`LPR_ASSERT_NOW(a_last_ends_line, out_v_q && last_q, !active_q)
	`LPR_ASSERT_NOW(a_write_on_screen, out_v_q && wen_q, !out_x_q[CoordBits-1] && !out_y_q[CoordBits-1])

endmodule

`default_nettype wire
